FILE: src/nfc_pkg.sv
// nfc_pkg: shared types and constants for the newline frame collector
// used by nfc_front, nfc_back and newline_frame_collector_unit; no dependencies
package nfc_pkg;

    localparam logic [7:0]  NEWLINE_BYTE  = 8'h0A;
    localparam logic [7:0]  DEL_BYTE      = 8'h7F;
    localparam logic [7:0]  MIN_PRINTABLE = 8'h30;
    localparam logic [7:0]  MAX_PRINTABLE = 8'h7F;
    localparam int          EARLY_LIMIT   = 3;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2500;
    localparam logic        REG_TIMEOUT   = 1'b0;

    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_NEWLINE,
        KIND_DEL,
        KIND_EARLY_BAD,
        KIND_PLAIN
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } q_head_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_RD,
        BK_WR
    } back_state_t;

endpackage

FILE: src/nfc_ram.sv
// nfc_ram: generic single write port, single read port ram with registered read
// no dependencies
module nfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/nfc_front.sv
// nfc_front: accepts input beats, classifies them and holds them in a two-entry queue
// depends on nfc_pkg
module nfc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_command,
    input  logic [7:0]       in_byte,
    output nfc_pkg::q_head_t head,
    input  logic             pop
);

    nfc_pkg::op_t q_data_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    nfc_pkg::op_t op_in;
    logic         push;
    logic         do_pop;

    // stateless part of the byte tests; fill-dependent tests are left to the back end
    always_comb
    begin
        op_in.data = in_byte;
        if (in_command)
        begin
            op_in.kind = nfc_pkg::KIND_TICK;
        end
        else if (in_byte == nfc_pkg::NEWLINE_BYTE)
        begin
            op_in.kind = nfc_pkg::KIND_NEWLINE;
        end
        else if (in_byte == nfc_pkg::DEL_BYTE)
        begin
            op_in.kind = nfc_pkg::KIND_DEL;
        end
        else if (!(in_byte inside {[nfc_pkg::MIN_PRINTABLE:nfc_pkg::MAX_PRINTABLE]}))
        begin
            op_in.kind = nfc_pkg::KIND_EARLY_BAD;
        end
        else
        begin
            op_in.kind = nfc_pkg::KIND_PLAIN;
        end
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.op    = q_data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (do_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

FILE: src/nfc_back.sv
// nfc_back: frame store, fill and idle counters, and the frame dump sequencer
// depends on nfc_pkg and nfc_ram
module nfc_back #(
    parameter int FRAME_BYTES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  nfc_pkg::q_head_t head,
    output logic             pop,
    input  logic [15:0]      idle_timeout_ms,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic [5:0]       out_index,
    output logic [6:0]       out_length,
    output logic             out_last
);

    localparam int IDX_W  = $clog2(FRAME_BYTES);
    localparam int FILL_W = $clog2(FRAME_BYTES + 1);
    localparam logic [FILL_W-1:0] FULL_FILL  = FILL_W'(FRAME_BYTES);
    localparam logic [FILL_W-1:0] EARLY_FILL = FILL_W'(nfc_pkg::EARLY_LIMIT);
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(FRAME_BYTES - 1);

    nfc_pkg::back_state_t state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       idle_reg, idle_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic [5:0]        out_index_reg, out_index_next;
    logic [6:0]        out_length_reg, out_length_next;
    logic              ram_we, ram_re;
    logic [7:0]        ram_rdata;
    logic [16:0]       idle_inc;
    logic              store_ok;

    nfc_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[IDX_W-1:0]),
        .wdata (head.op.data),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign idle_inc = {1'b0, idle_reg} + 17'd1;
    assign store_ok = (fill_reg < FULL_FILL) &&
                      !((head.op.kind == nfc_pkg::KIND_EARLY_BAD) && (fill_reg < EARLY_FILL));

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        idle_next       = idle_reg;
        idx_next        = idx_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        out_last_next   = out_last_reg;
        out_byte_next   = out_byte_reg;
        out_index_next  = out_index_reg;
        out_length_next = out_length_reg;

        case (state_reg)
            nfc_pkg::BK_RUN:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (head.op.kind)
                        nfc_pkg::KIND_TICK:
                        begin
                            if ((fill_reg != '0) && (idle_inc > {1'b0, idle_timeout_ms}))
                            begin
                                fill_next = '0;
                            end
                            idle_next = idle_inc[16] ? 16'hFFFF : idle_inc[15:0];
                        end
                        nfc_pkg::KIND_NEWLINE:
                        begin
                            idle_next  = '0;
                            idx_next   = '0;
                            state_next = nfc_pkg::BK_RD;
                        end
                        nfc_pkg::KIND_DEL:
                        begin
                            idle_next = '0;
                            fill_next = '0;
                        end
                        default:
                        begin
                            idle_next = '0;
                            if (store_ok)
                            begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + FILL_W'(1);
                            end
                            else
                            begin
                                fill_next = '0;
                            end
                        end
                    endcase
                end
            end
            nfc_pkg::BK_RD:
            begin
                ram_re     = 1'b1;
                state_next = nfc_pkg::BK_WR;
            end
            nfc_pkg::BK_WR:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = (idx_reg == LAST_IDX);
                    // positions past the fill point read as zero
                    out_byte_next   = ({1'b0, idx_reg} < fill_reg) ? ram_rdata : 8'h00;
                    out_index_next  = 6'(idx_reg);
                    out_length_next = 7'(fill_reg);
                    if (idx_reg == LAST_IDX)
                    begin
                        fill_next  = '0;
                        state_next = nfc_pkg::BK_RUN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = nfc_pkg::BK_RD;
                    end
                end
            end
            default:
            begin
                state_next = nfc_pkg::BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfc_pkg::BK_RUN;
            fill_reg      <= '0;
            idle_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idle_reg      <= idle_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_last_reg   <= out_last_next;
        out_byte_reg   <= out_byte_next;
        out_index_reg  <= out_index_next;
        out_length_reg <= out_length_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_index  = out_index_reg;
    assign out_length = out_length_reg;
    assign out_last   = out_last_reg;

endmodule

FILE: src/newline_frame_collector_unit.sv
// newline_frame_collector_unit: top level, apb timeout register, front queue and back end
// depends on nfc_pkg, nfc_front, nfc_back (and nfc_ram through nfc_back)
// a byte or tick beat is queued and then retired by the back end, which pops only in BK_RUN;
// a newline starts a dump of FRAME_BYTES beats, each a registered store read (BK_RD), then an
// output register load (BK_WR), held while output stalls; the two-entry queue fills meanwhile
// reset: timeout 2500, fill and idle counts zero; the store is not swept, the fill count masks it
module newline_frame_collector_unit #(
    parameter int FRAME_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] received_byte
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] frame_byte, [13:8] byte_index, [20:14] filled_length
    output logic        m_tlast,   // last_byte
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]      timeout_reg, timeout_next;
    nfc_pkg::q_head_t head;
    logic             pop;
    logic [7:0]       out_byte;
    logic [5:0]       out_index;
    logic [6:0]       out_length;

    assign pready = 1'b1;

    always_comb
    begin
        timeout_next = timeout_reg;
        if (psel && penable && pwrite && (paddr[2] == nfc_pkg::REG_TIMEOUT))
        begin
            timeout_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= nfc_pkg::TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    assign prdata = (paddr[2] == nfc_pkg::REG_TIMEOUT) ? {16'h0000, timeout_reg} : 32'h0;

    nfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tuser),
        .in_byte    (s_tdata),
        .head       (head),
        .pop        (pop)
    );

    nfc_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .pop             (pop),
        .idle_timeout_ms (timeout_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_byte        (out_byte),
        .out_index       (out_index),
        .out_length      (out_length),
        .out_last        (m_tlast)
    );

    assign m_tdata = {3'b000, out_length, out_index, out_byte};

    // last beat sits at the final position of the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[13:8] == 6'(FRAME_BYTES - 1)))
        else $error("last mark away from final frame position");

    // bytes past the fill point are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ({1'b0, m_tdata[13:8]} >= m_tdata[20:14])) |-> (m_tdata[7:0] == 8'h00))
        else $error("non-zero byte past fill point");

    // fill length never exceeds the frame size
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[20:14] <= 7'(FRAME_BYTES)))
        else $error("filled length beyond frame size");

    // a beat that follows a non-final accepted beat carries the next position
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid
        |-> (m_tdata[13:8] == $past(m_tdata[13:8], 1) + 6'd1))
        else $error("frame positions out of order");

endmodule
